// ===== rtl/core/bb3_pkg.sv =====
`default_nettype none
package bb3_pkg;

    localparam int PIX_W = 24;
    localparam int RECIP_SHIFT = 22;
    localparam int NUM_W = 13;
    localparam int PROD_W = NUM_W + RECIP_SHIFT;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic [2:0][2:0][PIX_W-1:0] win;
        logic [15:0]                row;
        logic [9:0]                 col;
        logic                       row_ge1;
        logic                       row_ge2;
        logic                       col_ge1;
        logic                       col_ge2;
        logic                       row_end;
        logic                       last_row;
    } job_t;

    typedef enum logic {
        F_IDLE,
        F_LOAD
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CALC,
        B_MUL,
        B_OUT
    } back_state_t;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // ceil(2^22 / (2*count)) for count 1..9
    function automatic logic [RECIP_SHIFT-1:0] recip(input logic [3:0] count);
        logic [RECIP_SHIFT-1:0] r;
        unique case (count)
            4'd1:    r = 22'd2097152;
            4'd2:    r = 22'd1048576;
            4'd3:    r = 22'd699051;
            4'd4:    r = 22'd524288;
            4'd5:    r = 22'd419431;
            4'd6:    r = 22'd349526;
            4'd7:    r = 22'd299594;
            4'd8:    r = 22'd262144;
            4'd9:    r = 22'd233017;
            default: r = 22'd2097152;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] bits3(input logic [2:0] m);
        return {1'b0, m[0]} + {1'b0, m[1]} + {1'b0, m[2]};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bb3_front.sv =====
`default_nettype none
module bb3_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_red_in,
    input  wire logic [7:0]    s_green_in,
    input  wire logic [7:0]    s_blue_in,
    input  wire logic [10:0]   image_width,
    input  wire logic [15:0]   image_height,
    input  wire logic          q_full,
    output logic               push,
    output bb3_pkg::job_t      job
);
    import bb3_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = ((CW > 11) ? CW : 11) + 1;

    front_state_t state_reg, state_next;

    pix_t older_mem [MAX_WIDTH];
    pix_t newer_mem [MAX_WIDTH];
    pix_t older_rd_reg, newer_rd_reg, pix_reg;

    logic [2:0][2:0][PIX_W-1:0] win_reg, win_next;
    logic [CW-1:0] col_reg, col_next;
    logic [15:0]   row_reg, row_next;

    logic [WW-1:0] w_eff;
    logic [16:0]   h_eff;
    logic          row_end, last_row, accept;

    assign accept = s_valid && s_ready;

    always_comb begin
        if (image_width == 11'd0) begin
            w_eff = WW'(1);
        end else if (WW'(image_width) > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(image_width);
        end
        h_eff    = (image_height == 16'd0) ? 17'd1 : {1'b0, image_height};
        row_end  = (WW'(col_reg) + WW'(1)) >= w_eff;
        last_row = ({1'b0, row_reg} + 17'd1) >= h_eff;
    end

    always_comb begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = {pix_reg, newer_rd_reg, older_rd_reg};
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = F_LOAD;
                end
            end
            F_LOAD: state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready      = (state_reg == F_IDLE) && !q_full;
        push         = (state_reg == F_LOAD);
        job.win      = win_next;
        job.row      = row_reg;
        job.col      = 10'(col_reg);
        job.row_ge1  = row_reg >= 16'd1;
        job.row_ge2  = row_reg >= 16'd2;
        job.col_ge1  = WW'(col_reg) >= WW'(1);
        job.col_ge2  = WW'(col_reg) >= WW'(2);
        job.row_end  = row_end;
        job.last_row = last_row;
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (row_end) begin
            col_next = '0;
            row_next = last_row ? 16'd0 : row_reg + 16'd1;
        end else begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == F_LOAD) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            older_rd_reg <= older_mem[col_reg];
            newer_rd_reg <= newer_mem[col_reg];
            pix_reg      <= {s_red_in, s_green_in, s_blue_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == F_LOAD) begin
            older_mem[col_reg] <= newer_rd_reg;
            newer_mem[col_reg] <= pix_reg;
            win_reg            <= win_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/bb3_queue.sv =====
`default_nettype none
module bb3_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire bb3_pkg::job_t push_job,
    input  wire logic          pop,
    output bb3_pkg::job_t      head,
    output logic               empty,
    output logic               full
);
    import bb3_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/bb3_back.sv =====
`default_nettype none
module bb3_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire bb3_pkg::job_t head,
    input  wire logic          empty,
    output logic               pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [7:0]         m_red_out,
    output logic [7:0]         m_green_out,
    output logic [7:0]         m_blue_out,
    output logic [15:0]        m_out_row,
    output logic [9:0]         m_out_col,
    output logic               m_last_of_run,
    output logic               m_frame_done
);
    import bb3_pkg::*;

    back_state_t state_reg, state_next;

    logic [3:0] pend_reg;
    logic [3:0] present;
    logic [1:0] sel;
    logic [3:0] pend_after;
    logic [2:0] rmask, cmask;
    logic [3:0] count;
    logic [11:0] sum_r, sum_g, sum_b;

    logic [NUM_W-1:0]       num_r_reg, num_g_reg, num_b_reg;
    logic [RECIP_SHIFT-1:0] recip_reg;
    logic [PROD_W-1:0]      prod_r_reg, prod_g_reg, prod_b_reg;
    logic [15:0] row_reg;
    logic [9:0]  col_reg;
    logic        last_reg, frame_reg;
    logic        out_done;

    // emits: 0 upper row mid, 1 upper row end, 2 last row mid, 3 last row end
    always_comb begin
        present[0] = head.row_ge1 && head.col_ge1;
        present[1] = head.row_ge1 && head.row_end;
        present[2] = head.last_row && head.col_ge1;
        present[3] = head.last_row && head.row_end;
    end

    always_comb begin
        priority if (pend_reg[0]) begin
            sel = 2'd0;
        end else if (pend_reg[1]) begin
            sel = 2'd1;
        end else if (pend_reg[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
        pend_after      = pend_reg;
        pend_after[sel] = 1'b0;
        rmask = sel[1] ? {1'b1, head.row_ge1, 1'b0} : {2'b11, head.row_ge2};
        cmask = sel[0] ? {1'b1, head.col_ge1, 1'b0} : {2'b11, head.col_ge2};
        count = {2'b00, bits3(rmask)} * {2'b00, bits3(cmask)};
    end

    always_comb begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int x = 0; x < 3; x++) begin
            for (int y = 0; y < 3; y++) begin
                if (cmask[x] && rmask[y]) begin
                    sum_r = sum_r + 12'(head.win[x][y][23:16]);
                    sum_g = sum_g + 12'(head.win[x][y][15:8]);
                    sum_b = sum_b + 12'(head.win[x][y][7:0]);
                end
            end
        end
    end

    assign out_done = m_valid && m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (!empty && (present != 4'd0)) begin
                    state_next = B_CALC;
                end
            end
            B_CALC: state_next = B_MUL;
            B_MUL:  state_next = B_OUT;
            B_OUT: begin
                if (out_done) begin
                    state_next = (pend_reg == 4'd0) ? B_IDLE : B_CALC;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        pop           = ((state_reg == B_IDLE) && !empty && (present == 4'd0))
                     || ((state_reg == B_OUT) && out_done && (pend_reg == 4'd0));
        m_valid       = (state_reg == B_OUT);
        m_red_out     = prod_r_reg[RECIP_SHIFT+7:RECIP_SHIFT];
        m_green_out   = prod_g_reg[RECIP_SHIFT+7:RECIP_SHIFT];
        m_blue_out    = prod_b_reg[RECIP_SHIFT+7:RECIP_SHIFT];
        m_out_row     = row_reg;
        m_out_col     = col_reg;
        m_last_of_run = last_reg;
        m_frame_done  = frame_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            pend_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_IDLE && !empty) begin
                pend_reg <= present;
            end else if (state_reg == B_CALC) begin
                pend_reg <= pend_after;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_CALC) begin
            num_r_reg <= {sum_r, 1'b0} + NUM_W'(count);
            num_g_reg <= {sum_g, 1'b0} + NUM_W'(count);
            num_b_reg <= {sum_b, 1'b0} + NUM_W'(count);
            recip_reg <= recip(count);
            row_reg   <= sel[1] ? head.row : head.row - 16'd1;
            col_reg   <= sel[0] ? head.col : head.col - 10'd1;
            last_reg  <= (pend_after == 4'd0);
            frame_reg <= (pend_after == 4'd0) && (sel == 2'd3);
        end
        if (state_reg == B_MUL) begin
            prod_r_reg <= PROD_W'(num_r_reg) * PROD_W'(recip_reg);
            prod_g_reg <= PROD_W'(num_g_reg) * PROD_W'(recip_reg);
            prod_b_reg <= PROD_W'(num_b_reg) * PROD_W'(recip_reg);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/box_blur_3x3_edge_aware.sv =====
// the first result of a pixel is valid in the back out state, after front load, the job queue, back calc and mul
// front takes a new pixel only after the last one's line store read and write back, and while the queue is not full
// back steps through calc, mul and out for each result after idle for each pixel, up to 4 results per pixel
// a 2-entry job queue lets front and back stall independently
// reset: synchronous active low, counters at zero, width 1024, height 1
// line stores need no clearing pass
`default_nettype none
module box_blur_3x3_edge_aware #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_red_in,
    input  wire logic [7:0]  s_green_in,
    input  wire logic [7:0]  s_blue_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_red_out,
    output logic [7:0]       m_green_out,
    output logic [7:0]       m_blue_out,
    output logic [15:0]      m_out_row,
    output logic [9:0]       m_out_col,
    output logic             m_last_of_run,
    output logic             m_frame_done
);
    import bb3_pkg::*;

    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic        push, pop, q_full, q_empty;
    job_t        push_job, head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 11'd1024;
            height_reg <= 16'd1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data[10:0];
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    bb3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red_in     (s_red_in),
        .s_green_in   (s_green_in),
        .s_blue_in    (s_blue_in),
        .image_width  (width_reg),
        .image_height (height_reg),
        .q_full       (q_full),
        .push         (push),
        .job          (push_job)
    );

    bb3_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    bb3_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .empty         (q_empty),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_out     (m_red_out),
        .m_green_out   (m_green_out),
        .m_blue_out    (m_blue_out),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_last_of_run (m_last_of_run),
        .m_frame_done  (m_frame_done)
    );

endmodule
`default_nettype wire

// ===== test/box_blur_3x3_edge_aware_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module box_blur_3x3_edge_aware_tb;
    import bb3_pkg::*;

    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] row;
        logic [9:0]  col;
        logic        last_of_run;
        logic        frame_done;
    } blurred_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_red_in;
    logic [7:0]  s_green_in;
    logic [7:0]  s_blue_in;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_red_out;
    logic [7:0]  m_green_out;
    logic [7:0]  m_blue_out;
    logic [15:0] m_out_row;
    logic [9:0]  m_out_col;
    logic        m_last_of_run;
    logic        m_frame_done;

    box_blur_3x3_edge_aware dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_red_in(s_red_in),
        .s_green_in(s_green_in),
        .s_blue_in(s_blue_in),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_red_out(m_red_out),
        .m_green_out(m_green_out),
        .m_blue_out(m_blue_out),
        .m_out_row(m_out_row),
        .m_out_col(m_out_col),
        .m_last_of_run(m_last_of_run),
        .m_frame_done(m_frame_done)
    );

    // blur predictor state
    logic [23:0] older_row_buf [1024];
    logic [23:0] newer_row_buf [1024];
    logic [23:0] window [3][3];
    int unsigned row_pos;
    int unsigned col_pos;
    logic [10:0] width_reg;
    logic [15:0] height_reg;

    blurred_t pending_pixels[$];
    int       mismatch_count;
    int       pixels_sent;
    int       idle_pct;
    int       stall_pct;
    bit       hold_request;
    int       hold_left;

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int unsigned count_bits(input logic [2:0] m);
        return m[0] + m[1] + m[2];
    endfunction

    function automatic blurred_t blur_at(input int unsigned r, input int unsigned c,
                                         input logic [2:0] rmask, input logic [2:0] cmask);
        blurred_t    b;
        int unsigned sr, sg, sb, n;
        sr = 0;
        sg = 0;
        sb = 0;
        n = count_bits(rmask) * count_bits(cmask);
        for (int x = 0; x < 3; x++) begin
            for (int y = 0; y < 3; y++) begin
                if (cmask[x] && rmask[y]) begin
                    sr += window[x][y][23:16];
                    sg += window[x][y][15:8];
                    sb += window[x][y][7:0];
                end
            end
        end
        if (n == 0) n = 1;
        b.red = 8'((2 * sr + n) / (2 * n));
        b.green = 8'((2 * sg + n) / (2 * n));
        b.blue = 8'((2 * sb + n) / (2 * n));
        b.row = 16'(r);
        b.col = 10'(c);
        b.last_of_run = 1'b0;
        b.frame_done = 1'b0;
        return b;
    endfunction

    task automatic predict_blur(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        blurred_t    run[$];
        int unsigned w, h, i, j;
        logic [23:0] pix;
        logic [2:0]  rows, cols_mid, cols_end;
        bit          row_end, last_row;
        w = width_reg;
        h = height_reg;
        i = row_pos;
        j = col_pos;
        if (w < 1) w = 1;
        if (w > 1024) w = 1024;
        if (h < 1) h = 1;
        if (j >= 1024) j = 1023;
        pix = {r, g, b};
        for (int x = 0; x < 2; x++) begin
            for (int y = 0; y < 3; y++) window[x][y] = window[x + 1][y];
        end
        window[2][0] = older_row_buf[j];
        window[2][1] = newer_row_buf[j];
        window[2][2] = pix;
        older_row_buf[j] = newer_row_buf[j];
        newer_row_buf[j] = pix;
        row_end = j >= w - 1;
        last_row = i >= h - 1;
        cols_mid = {2'b11, j >= 2};
        cols_end = {1'b1, j >= 1, 1'b0};
        if (i >= 1) begin
            rows = {2'b11, i >= 2};
            if (j >= 1) run.push_back(blur_at(i - 1, j - 1, rows, cols_mid));
            if (row_end) run.push_back(blur_at(i - 1, j, rows, cols_end));
        end
        if (last_row) begin
            rows = {1'b1, i >= 1, 1'b0};
            if (j >= 1) run.push_back(blur_at(i, j - 1, rows, cols_mid));
            if (row_end) run.push_back(blur_at(i, j, rows, cols_end));
        end
        if (run.size() > 0) begin
            run[run.size() - 1].last_of_run = 1'b1;
            if (last_row && row_end) run[run.size() - 1].frame_done = 1'b1;
        end
        foreach (run[k]) pending_pixels.push_back(run[k]);
        if (row_end) begin
            col_pos = 0;
            row_pos = last_row ? 0 : ((i + 1) & 16'hFFFF);
        end else begin
            col_pos = j + 1;
        end
    endtask

    // receiver: check accepted results, then choose next ready
    always @(posedge aclk) begin
        blurred_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    $error("result with no request pending: row %0d col %0d",
                           m_out_row, m_out_col);
                    mismatch_count++;
                end else begin
                    e = pending_pixels.pop_front();
                    if (m_red_out !== e.red) begin
                        $error("red_out expected %0d got %0d", e.red, m_red_out);
                        mismatch_count++;
                    end
                    if (m_green_out !== e.green) begin
                        $error("green_out expected %0d got %0d", e.green, m_green_out);
                        mismatch_count++;
                    end
                    if (m_blue_out !== e.blue) begin
                        $error("blue_out expected %0d got %0d", e.blue, m_blue_out);
                        mismatch_count++;
                    end
                    if (m_out_row !== e.row) begin
                        $error("out_row expected %0d got %0d", e.row, m_out_row);
                        mismatch_count++;
                    end
                    if (m_out_col !== e.col) begin
                        $error("out_col expected %0d got %0d", e.col, m_out_col);
                        mismatch_count++;
                    end
                    if (m_last_of_run !== e.last_of_run) begin
                        $error("last_of_run expected %0d got %0d", e.last_of_run,
                               m_last_of_run);
                        mismatch_count++;
                    end
                    if (m_frame_done !== e.frame_done) begin
                        $error("frame_done expected %0d got %0d", e.frame_done,
                               m_frame_done);
                        mismatch_count++;
                    end
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_WIDTH) width_reg = data[10:0];
        else height_reg = data;
        @(posedge aclk);
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid <= 1'b1;
        s_red_in <= r;
        s_green_in <= g;
        s_blue_in <= b;
        do @(posedge aclk); while (!s_ready);
        predict_blur(r, g, b);
        pixels_sent++;
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_phase(input int n);
        case (n % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 56; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 56; end
            default: begin idle_pct = 35; stall_pct = 35; end
        endcase
    endtask

    task automatic send_frame(input int unsigned w, input int unsigned h);
        logic [7:0] c [3];
        for (int n = 0; n < w * h; n++) begin
            for (int k = 0; k < 3; k++) begin
                case ($urandom_range(3))
                    0: c[k] = 8'd0;
                    1: c[k] = 8'd255;
                    default: c[k] = 8'($urandom);
                endcase
            end
            send_pixel(c[0], c[1], c[2]);
        end
    endtask

    task automatic test_reset_defaults;
        // part of a row with the reset setting, then a width write ends the row
        set_phase(0);
        for (int n = 0; n < 40; n++) begin
            if (n % 2 == 0) send_pixel(8'd255, 8'd0, 8'd255);
            else send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end
        drain();
        write_reg(CFG_WIDTH, 16'd41);
        send_pixel(8'd17, 8'd34, 8'd51);
        drain();
    endtask

    task automatic test_small_frames;
        set_phase(0);
        write_reg(CFG_WIDTH, 16'd0);
        write_reg(CFG_HEIGHT, 16'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        drain();
        write_reg(CFG_WIDTH, 16'd1);
        write_reg(CFG_HEIGHT, 16'd3);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd0, 8'd255, 8'd2);
        send_pixel(8'd255, 8'd0, 8'd3);
        drain();
        write_reg(CFG_WIDTH, 16'd2);
        write_reg(CFG_HEIGHT, 16'd2);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd1, 8'd0, 8'd255);
        drain();
        // rounding for the divisors four, six and nine of a full three by three frame
        write_reg(CFG_WIDTH, 16'd3);
        write_reg(CFG_HEIGHT, 16'd3);
        for (int n = 0; n < 9; n++) send_pixel(8'(n * 29 + 1), 8'(255 - n), 8'(n % 2));
        drain();
    endtask

    task automatic test_height_change_mid_frame;
        set_phase(3);
        write_reg(CFG_WIDTH, 16'd3);
        write_reg(CFG_HEIGHT, 16'd65535);
        send_frame(3, 2);
        drain();
        write_reg(CFG_HEIGHT, 16'd3);
        send_frame(3, 1);
        drain();
    endtask

    task automatic test_width_over_range;
        set_phase(1);
        write_reg(CFG_WIDTH, 16'd2047);
        write_reg(CFG_HEIGHT, 16'd1);
        send_frame(30, 1);
        drain();
        write_reg(CFG_WIDTH, 16'd31);
        send_frame(1, 1);
        drain();
    endtask

    task automatic test_backpressure;
        set_phase(0);
        write_reg(CFG_WIDTH, 16'd5);
        write_reg(CFG_HEIGHT, 16'd8);
        hold_request = 1'b1;
        send_frame(5, 8);
        drain();
    endtask

    task automatic test_random_frames;
        int unsigned w, h, frame_idx, start;
        frame_idx = 0;
        start = pixels_sent;
        while (pixels_sent - start < 210) begin
            w = ($urandom_range(7) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            set_phase(frame_idx++);
            write_reg(CFG_WIDTH, 16'(w));
            write_reg(CFG_HEIGHT, 16'(h));
            send_frame(w, h);
            drain();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data = '0;
        s_valid = 1'b0;
        s_red_in = '0;
        s_green_in = '0;
        s_blue_in = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_request = 1'b0;
        hold_left = 0;
        mismatch_count = 0;
        pixels_sent = 0;
        for (int k = 0; k < 1024; k++) begin
            older_row_buf[k] = '0;
            newer_row_buf[k] = '0;
        end
        for (int x = 0; x < 3; x++) begin
            for (int y = 0; y < 3; y++) window[x][y] = '0;
        end
        row_pos = 0;
        col_pos = 0;
        width_reg = 11'd1024;
        height_reg = 16'd1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_small_frames();
        test_height_change_mid_frame();
        test_width_over_range();
        test_backpressure();
        test_random_frames();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/bb3_pkg.sv
rtl/core/bb3_front.sv
rtl/core/bb3_queue.sv
rtl/core/bb3_back.sv
rtl/core/box_blur_3x3_edge_aware.sv
test/box_blur_3x3_edge_aware_tb.sv
